// ===== hw/rtl/tcc_pkg.sv =====
// Shared widths, command and status codes, and controller states of the triplet converter.
package tcc_pkg;

	localparam int OP_W      = 3;
	localparam int ROW_W     = 16;
	localparam int COL_W     = 8;
	localparam int VAL_W     = 64;
	localparam int RIDX_W    = 11;
	localparam int STAT_W    = 3;
	localparam int PTR_W     = 11;
	localparam int CNT_OUT_W = 11;
	localparam int NCOL_W    = 9;

	localparam int MAX_ENTRIES_DEF = 1024;
	localparam int MAX_COLS_DEF    = 256;

	localparam logic [NCOL_W-1:0] NUM_COLS_RST = 9'd256;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND   = 3'd0,
		OP_COMPRESS = 3'd1,
		OP_RD_PTR   = 3'd2,
		OP_RD_ENTRY = 3'd3,
		OP_CLEAR    = 3'd4
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 3'd0,
		ST_FULL    = 3'd1,
		ST_COL     = 3'd2,
		ST_BADREAD = 3'd3,
		ST_NOTCOMP = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE  = 3'd0,
		S_ZERO  = 3'd1,
		S_COUNT = 3'd2,
		S_SCAN  = 3'd3,
		S_FINAL = 3'd4,
		S_PLACE = 3'd5
	} state_t;

endpackage

// ===== hw/rtl/tcc_ram.sv =====
// Generic single-write, single-read RAM with registered read data (read-first).
module tcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/triplet_to_csc_converter_core.sv =====
// Top level: triplet load store, compress sequencer and compressed-column read port.
// Append, read, clear and unknown commands: result strobe in the cycle after acceptance,
//   one command per cycle while not busy, since each touches one RAM port once.
// Compress: busy through its walk over the load store and the column table,
//   one RAM access per cycle; done rises as busy falls.
// Reset clears the entry count, the compressed flag and the controller and sets num_cols
//   to 256; RAM contents are left as they are, with no clearing pass.
module triplet_to_csc_converter_core #(
	parameter int MAX_ENTRIES = tcc_pkg::MAX_ENTRIES_DEF,
	parameter int MAX_COLS    = tcc_pkg::MAX_COLS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [tcc_pkg::OP_W-1:0]     op,
	input  logic [tcc_pkg::ROW_W-1:0]    row_index,
	input  logic [tcc_pkg::COL_W-1:0]    col_index,
	input  logic [tcc_pkg::VAL_W-1:0]    value_word,
	input  logic [tcc_pkg::RIDX_W-1:0]   read_index,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [tcc_pkg::NCOL_W-1:0]   cfg_data,
	output logic                         done,
	output logic [tcc_pkg::STAT_W-1:0]   status,
	output logic [tcc_pkg::PTR_W-1:0]    pointer_out,
	output logic [tcc_pkg::ROW_W-1:0]    row_out,
	output logic [tcc_pkg::VAL_W-1:0]    value_out,
	output logic [tcc_pkg::CNT_OUT_W-1:0] entry_count
);

	// entry counts and column pointers hold 0..MAX_ENTRIES
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int EA_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	// column counts hold 0..MAX_COLS, column addresses 0..MAX_COLS-1
	localparam int NC_W  = $clog2(MAX_COLS + 1);
	localparam int CA_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int IDX_W = (CNT_W > NC_W) ? CNT_W : NC_W;
	localparam int ROW_W = tcc_pkg::ROW_W;
	localparam int COL_W = tcc_pkg::COL_W;
	localparam int VAL_W = tcc_pkg::VAL_W;
	localparam int LD_W  = ROW_W + COL_W + VAL_W;
	localparam int PK_W  = ROW_W + VAL_W;

	// ------------------------------------------------------------------
	// Control and status registers
	// ------------------------------------------------------------------
	tcc_pkg::state_t  state_q, state_next;
	tcc_pkg::status_t status_q;

	logic [tcc_pkg::NCOL_W-1:0] num_cols_q;
	logic [CNT_W-1:0]           loaded_q;
	logic                       compressed_q;
	logic [NC_W-1:0]            packed_cols_q;
	logic [CNT_W-1:0]           packed_total_q;
	logic [IDX_W-1:0]           idx_q;
	logic [CNT_W-1:0]           sum_q;
	logic                       done_q;
	logic                       rd_ptr_q;
	logic                       rd_entry_q;

	// Walk pipeline: s1 = load-store read in flight, s2 = slot read in flight
	logic                       walk_v_s1;
	logic                       walk_v_s2;
	logic [CA_W-1:0]            col_s2;
	logic [ROW_W-1:0]           row_s2;
	logic [VAL_W-1:0]           val_s2;
	// Scan pipeline: slot read in flight
	logic                       scan_v_s1;
	logic [CA_W-1:0]            scan_col_s1;
	// Last slot write, forwarded to a read that raced it
	logic                       fwd_v_q;
	logic [CA_W-1:0]            fwd_col_q;
	logic [CNT_W-1:0]           fwd_data_q;

	// ------------------------------------------------------------------
	// Combinational helpers
	// ------------------------------------------------------------------
	logic             accept;
	logic [NC_W-1:0]  ncols;
	logic             loaded_full;
	logic             col_ok_in;
	logic             append_ok;
	logic             walk_issue_done;
	logic             scan_issue_done;
	logic             walk_drained;
	logic             issue_walk;
	logic             issue_scan;
	logic             zero_wr;
	logic             final_wr;

	logic [LD_W-1:0]  ld_rdata;
	logic [ROW_W-1:0] ld_row;
	logic [COL_W-1:0] ld_col;
	logic [VAL_W-1:0] ld_val;
	logic             ld_col_ok;

	logic [CNT_W-1:0] slot_rdata;
	logic [CNT_W-1:0] slot_old;
	logic [CNT_W-1:0] slot_inc;
	logic             slot_we;
	logic [CA_W-1:0]  slot_waddr;
	logic [CNT_W-1:0] slot_wdata;
	logic [CA_W-1:0]  slot_raddr;

	logic [CNT_W-1:0] cp_rdata;
	logic             cp_we;
	logic [NC_W-1:0]  cp_waddr;

	logic [PK_W-1:0]  pk_rdata;
	logic             pk_we;

	logic [31:0]      ptr32;
	logic [31:0]      cnt32;

	assign accept = start && !busy;

	// Effective column count: num_cols clipped to the table size
	assign ncols = (32'(num_cols_q) > 32'(MAX_COLS)) ? NC_W'(MAX_COLS) : NC_W'(num_cols_q);

	assign loaded_full = 32'(loaded_q) >= 32'(MAX_ENTRIES);
	assign col_ok_in   = 32'(col_index) < 32'(ncols);
	assign append_ok   = accept && (op == tcc_pkg::OP_APPEND) && !loaded_full && col_ok_in;

	assign walk_issue_done = 32'(idx_q) >= 32'(loaded_q);
	assign scan_issue_done = 32'(idx_q) >= 32'(ncols);
	assign walk_drained    = walk_issue_done && !walk_v_s1 && !walk_v_s2;

	assign ld_row    = ld_rdata[LD_W-1 -: ROW_W];
	assign ld_col    = ld_rdata[VAL_W +: COL_W];
	assign ld_val    = ld_rdata[VAL_W-1:0];
	// Entries whose column fell out of range after a shrink are skipped
	assign ld_col_ok = 32'(ld_col) < 32'(ncols);

	// A slot read issued while the previous entry wrote the same column sees stale data
	assign slot_old = (fwd_v_q && (fwd_col_q == col_s2)) ? fwd_data_q : slot_rdata;
	assign slot_inc = slot_old + CNT_W'(1);

	// ------------------------------------------------------------------
	// Sequencer: next state
	// ------------------------------------------------------------------
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			tcc_pkg::S_IDLE: begin
				if (accept && (op == tcc_pkg::OP_COMPRESS)) begin
					state_next = tcc_pkg::S_ZERO;
				end
			end
			tcc_pkg::S_ZERO: begin
				if (scan_issue_done) begin
					state_next = tcc_pkg::S_COUNT;
				end
			end
			tcc_pkg::S_COUNT: begin
				if (walk_drained) begin
					state_next = tcc_pkg::S_SCAN;
				end
			end
			tcc_pkg::S_SCAN: begin
				if (scan_issue_done && !scan_v_s1) begin
					state_next = tcc_pkg::S_FINAL;
				end
			end
			tcc_pkg::S_FINAL: begin
				state_next = tcc_pkg::S_PLACE;
			end
			tcc_pkg::S_PLACE: begin
				if (walk_drained) begin
					state_next = tcc_pkg::S_IDLE;
				end
			end
			default: begin
				state_next = tcc_pkg::S_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer: per-state controls
	// ------------------------------------------------------------------
	always_comb begin
		issue_walk = 1'b0;
		issue_scan = 1'b0;
		zero_wr    = 1'b0;
		final_wr   = 1'b0;
		unique case (state_q)
			tcc_pkg::S_ZERO:  zero_wr    = !scan_issue_done;
			tcc_pkg::S_COUNT: issue_walk = !walk_issue_done;
			tcc_pkg::S_SCAN:  issue_scan = !scan_issue_done;
			tcc_pkg::S_FINAL: final_wr   = 1'b1;
			tcc_pkg::S_PLACE: issue_walk = !walk_issue_done;
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Memories
	// ------------------------------------------------------------------
	// Load store: {row, column, value}, written by append, walked by compress
	tcc_ram #(
		.WIDTH(LD_W),
		.DEPTH(MAX_ENTRIES)
	) u_load_ram (
		.clk  (clk),
		.we   (append_ok),
		.waddr(EA_W'(loaded_q)),
		.wdata({row_index, col_index, value_word}),
		.raddr(EA_W'(idx_q)),
		.rdata(ld_rdata)
	);

	// Per-column counts, then next free slot
	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = CA_W'(idx_q);
		slot_wdata = '0;
		priority if (zero_wr) begin
			slot_we = 1'b1;
		end else if (walk_v_s2) begin
			slot_we    = 1'b1;
			slot_waddr = col_s2;
			slot_wdata = slot_inc;
		end else if (scan_v_s1) begin
			slot_we    = 1'b1;
			slot_waddr = scan_col_s1;
			slot_wdata = sum_q;
		end else begin
			slot_we = 1'b0;
		end
	end

	assign slot_raddr = issue_scan ? CA_W'(idx_q) : CA_W'(ld_col);

	tcc_ram #(
		.WIDTH(CNT_W),
		.DEPTH(MAX_COLS)
	) u_slot_ram (
		.clk  (clk),
		.we   (slot_we),
		.waddr(slot_waddr),
		.wdata(slot_wdata),
		.raddr(slot_raddr),
		.rdata(slot_rdata)
	);

	// Column pointers: exclusive prefix sum, plus the total at index ncols
	assign cp_we    = scan_v_s1 || final_wr;
	assign cp_waddr = final_wr ? ncols : NC_W'(scan_col_s1);

	tcc_ram #(
		.WIDTH(CNT_W),
		.DEPTH(MAX_COLS + 1)
	) u_colptr_ram (
		.clk  (clk),
		.we   (cp_we),
		.waddr(cp_waddr),
		.wdata(sum_q),
		.raddr(NC_W'(read_index)),
		.rdata(cp_rdata)
	);

	// Compressed entries: {row, value}
	assign pk_we = walk_v_s2 && (state_q == tcc_pkg::S_PLACE);

	tcc_ram #(
		.WIDTH(PK_W),
		.DEPTH(MAX_ENTRIES)
	) u_packed_ram (
		.clk  (clk),
		.we   (pk_we),
		.waddr(EA_W'(slot_old)),
		.wdata({row_s2, val_s2}),
		.raddr(EA_W'(read_index)),
		.rdata(pk_rdata)
	);

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= tcc_pkg::S_IDLE;
			num_cols_q     <= tcc_pkg::NUM_COLS_RST;
			loaded_q       <= '0;
			compressed_q   <= 1'b0;
			packed_cols_q  <= '0;
			packed_total_q <= '0;
			idx_q          <= '0;
			sum_q          <= '0;
			walk_v_s1      <= 1'b0;
			walk_v_s2      <= 1'b0;
			scan_v_s1      <= 1'b0;
			fwd_v_q        <= 1'b0;
			done_q         <= 1'b0;
			status_q       <= tcc_pkg::ST_OK;
			rd_ptr_q       <= 1'b0;
			rd_entry_q     <= 1'b0;
		end else begin
			state_q <= state_next;

			if (cfg_valid && cfg_ready) begin
				num_cols_q <= cfg_data;
			end

			// Restart the index at every phase change, advance it per issued access
			if (state_next != state_q) begin
				idx_q <= '0;
			end else if (issue_walk || issue_scan || zero_wr) begin
				idx_q <= idx_q + IDX_W'(1);
			end

			walk_v_s1 <= issue_walk;
			walk_v_s2 <= walk_v_s1 && ld_col_ok;
			scan_v_s1 <= issue_scan;
			fwd_v_q   <= walk_v_s2;

			if (state_q == tcc_pkg::S_ZERO) begin
				sum_q <= '0;
			end else if (scan_v_s1) begin
				sum_q <= sum_q + slot_rdata;
			end

			if (final_wr) begin
				packed_total_q <= sum_q;
				packed_cols_q  <= ncols;
			end

			// Result defaults: strobe lasts one cycle
			done_q     <= 1'b0;
			rd_ptr_q   <= 1'b0;
			rd_entry_q <= 1'b0;

			if ((state_q == tcc_pkg::S_PLACE) && walk_drained) begin
				compressed_q <= 1'b1;
				done_q       <= 1'b1;
				status_q     <= tcc_pkg::ST_OK;
			end

			if (accept && (op != tcc_pkg::OP_COMPRESS)) begin
				done_q   <= 1'b1;
				status_q <= tcc_pkg::ST_OK;
				unique case (op)
					tcc_pkg::OP_APPEND: begin
						if (loaded_full) begin
							status_q <= tcc_pkg::ST_FULL;
						end else if (!col_ok_in) begin
							status_q <= tcc_pkg::ST_COL;
						end else begin
							loaded_q     <= loaded_q + CNT_W'(1);
							compressed_q <= 1'b0;
						end
					end
					tcc_pkg::OP_RD_PTR: begin
						if (!compressed_q) begin
							status_q <= tcc_pkg::ST_NOTCOMP;
						end else if (32'(read_index) > 32'(packed_cols_q)) begin
							status_q <= tcc_pkg::ST_BADREAD;
						end else begin
							rd_ptr_q <= 1'b1;
						end
					end
					tcc_pkg::OP_RD_ENTRY: begin
						if (!compressed_q) begin
							status_q <= tcc_pkg::ST_NOTCOMP;
						end else if ((32'(read_index) >= 32'(packed_total_q)) ||
							(32'(read_index) >= 32'(MAX_ENTRIES))) begin
							status_q <= tcc_pkg::ST_BADREAD;
						end else begin
							rd_entry_q <= 1'b1;
						end
					end
					tcc_pkg::OP_CLEAR: begin
						loaded_q     <= '0;
						compressed_q <= 1'b0;
					end
					default: begin
						// unknown command: no state change, status ok
					end
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Pipeline payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		col_s2      <= CA_W'(ld_col);
		row_s2      <= ld_row;
		val_s2      <= ld_val;
		scan_col_s1 <= CA_W'(idx_q);
		fwd_col_q   <= col_s2;
		fwd_data_q  <= slot_inc;
	end

	// ------------------------------------------------------------------
	// Ports
	// ------------------------------------------------------------------
	assign busy      = state_q != tcc_pkg::S_IDLE;
	assign cfg_ready = !busy;
	assign done      = done_q;
	assign status    = status_q;

	assign ptr32       = 32'(cp_rdata);
	assign cnt32       = 32'(loaded_q);
	assign pointer_out = rd_ptr_q ? ptr32[tcc_pkg::PTR_W-1:0] : '0;
	assign row_out     = rd_entry_q ? pk_rdata[PK_W-1 -: ROW_W] : '0;
	assign value_out   = rd_entry_q ? pk_rdata[VAL_W-1:0] : '0;
	assign entry_count = cnt32[tcc_pkg::CNT_OUT_W-1:0];

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_compress_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (op == tcc_pkg::OP_COMPRESS) |=> busy)
		else $error("compress accepted but sequencer stayed idle");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (op != tcc_pkg::OP_COMPRESS) |=> done)
		else $error("missing result one cycle after a command");

	a_compress_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done && (status_q == tcc_pkg::ST_OK))
		else $error("compress ended without an ok result");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(loaded_q) <= 32'(MAX_ENTRIES))
		else $error("entry count beyond the load store");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pk_we |-> 32'(slot_old) < 32'(packed_total_q))
		else $error("scatter position beyond the compressed entry count");

endmodule

// ===== verif/triplet_to_csc_converter_core_tb.sv =====
// Self-checking testbench for the triplet-to-compressed-column converter core.
`timescale 1ns / 1ps

module triplet_to_csc_converter_core_tb;

	localparam int OP_W         = tcc_pkg::OP_W;
	localparam int ROW_W        = tcc_pkg::ROW_W;
	localparam int COL_W        = tcc_pkg::COL_W;
	localparam int VAL_W        = tcc_pkg::VAL_W;
	localparam int RIDX_W       = tcc_pkg::RIDX_W;
	localparam int STAT_W       = tcc_pkg::STAT_W;
	localparam int PTR_W        = tcc_pkg::PTR_W;
	localparam int CNT_OUT_W    = tcc_pkg::CNT_OUT_W;
	localparam int NCOL_W       = tcc_pkg::NCOL_W;
	localparam int NUM_SLOTS    = tcc_pkg::MAX_ENTRIES_DEF;
	localparam int NUM_COLS_MAX = tcc_pkg::MAX_COLS_DEF;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASE_ITEMS  = 55;

	// One command transaction as it sits on the input ports.
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [VAL_W-1:0]  val;
		logic [RIDX_W-1:0] ridx;
	} command_t;

	// One result transaction as it appears on the output ports.
	typedef struct packed {
		logic [STAT_W-1:0]    status;
		logic [PTR_W-1:0]     ptr;
		logic [ROW_W-1:0]     row;
		logic [VAL_W-1:0]     val;
		logic [CNT_OUT_W-1:0] count;
	} response_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  start       = 1'b0;
	logic                  busy;
	logic [OP_W-1:0]       op          = '0;
	logic [ROW_W-1:0]      row_index   = '0;
	logic [COL_W-1:0]      col_index   = '0;
	logic [VAL_W-1:0]      value_word  = '0;
	logic [RIDX_W-1:0]     read_index  = '0;
	logic                  cfg_valid   = 1'b0;
	logic                  cfg_ready;
	logic [NCOL_W-1:0]     cfg_data    = '0;
	logic                  done;
	logic [STAT_W-1:0]     status;
	logic [PTR_W-1:0]      pointer_out;
	logic [ROW_W-1:0]      row_out;
	logic [VAL_W-1:0]      value_out;
	logic [CNT_OUT_W-1:0]  entry_count;

	// Commands waiting for the driver, and results the converter still owes us.
	command_t  queued_commands[$];
	response_t predicted_results[$];

	// Predictor copy of the converter: load store, column table and packed store.
	logic [ROW_W-1:0]  ld_row    [NUM_SLOTS];
	logic [COL_W-1:0]  ld_col    [NUM_SLOTS];
	logic [VAL_W-1:0]  ld_val    [NUM_SLOTS];
	logic [PTR_W-1:0]  col_start [NUM_COLS_MAX + 1];
	logic [ROW_W-1:0]  csc_row   [NUM_SLOTS];
	logic [VAL_W-1:0]  csc_val   [NUM_SLOTS];
	int unsigned       n_loaded     = 0;
	bit                csc_ready    = 1'b0;
	int unsigned       csc_cols     = 0;
	logic [NCOL_W-1:0] cols_setting = tcc_pkg::NUM_COLS_RST;

	// Generator-side guess of the load count, used only to aim read indexes.
	int unsigned est_loaded = 0;
	int          idle_pct   = 0;

	int n_queued   = 0;
	int n_accepted = 0;
	int n_checked  = 0;
	int n_compress = 0;
	int n_cfg      = 0;
	int n_errors   = 0;
	int n_cycles   = 0;

	triplet_to_csc_converter_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.row_index   (row_index),
		.col_index   (col_index),
		.value_word  (value_word),
		.read_index  (read_index),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.done        (done),
		.status      (status),
		.pointer_out (pointer_out),
		.row_out     (row_out),
		.value_out   (value_out),
		.entry_count (entry_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Column count the converter actually uses: the register, saturated at the table size.
	function automatic int unsigned effective_cols();
		return (cols_setting > NUM_COLS_MAX) ? NUM_COLS_MAX : cols_setting;
	endfunction

	// Apply one accepted command to the predictor state and return the result it yields.
	function automatic response_t predict_response(input command_t c);
		response_t   r;
		int unsigned ncols;
		int unsigned fill [NUM_COLS_MAX];
		int unsigned sum;
		int unsigned slot;
		r = '0;
		ncols = effective_cols();
		case (c.op)
		tcc_pkg::OP_APPEND: begin
			// Store full wins over a bad column.
			if (n_loaded >= NUM_SLOTS) begin
				r.status = tcc_pkg::ST_FULL;
			end else if (c.col >= ncols) begin
				r.status = tcc_pkg::ST_COL;
			end else begin
				ld_row[n_loaded] = c.row;
				ld_col[n_loaded] = c.col;
				ld_val[n_loaded] = c.val;
				n_loaded++;
				csc_ready = 1'b0;
			end
		end
		tcc_pkg::OP_COMPRESS: begin
			// Count per column, skipping entries left beyond a shrunk column count.
			for (int j = 0; j < ncols; j++)
				fill[j] = 0;
			for (int k = 0; k < n_loaded; k++)
				if (ld_col[k] < ncols)
					fill[ld_col[k]]++;
			// Exclusive prefix sum gives the column starts and the first free slots.
			sum = 0;
			for (int j = 0; j < ncols; j++) begin
				slot = fill[j];
				col_start[j] = PTR_W'(sum);
				fill[j] = sum;
				sum += slot;
			end
			col_start[ncols] = PTR_W'(sum);
			// Scatter in load order, so each column keeps its arrival order.
			for (int k = 0; k < n_loaded; k++) begin
				if (ld_col[k] < ncols) begin
					slot = fill[ld_col[k]];
					fill[ld_col[k]]++;
					if (slot < NUM_SLOTS) begin
						csc_row[slot] = ld_row[k];
						csc_val[slot] = ld_val[k];
					end
				end
			end
			csc_cols = ncols;
			csc_ready = 1'b1;
			n_compress++;
		end
		tcc_pkg::OP_RD_PTR: begin
			if (!csc_ready)
				r.status = tcc_pkg::ST_NOTCOMP;
			else if (c.ridx > csc_cols)
				r.status = tcc_pkg::ST_BADREAD;
			else
				r.ptr = col_start[c.ridx];
		end
		tcc_pkg::OP_RD_ENTRY: begin
			if (!csc_ready) begin
				r.status = tcc_pkg::ST_NOTCOMP;
			end else if (c.ridx >= col_start[csc_cols] || c.ridx >= NUM_SLOTS) begin
				r.status = tcc_pkg::ST_BADREAD;
			end else begin
				r.row = csc_row[c.ridx];
				r.val = csc_val[c.ridx];
			end
		end
		tcc_pkg::OP_CLEAR: begin
			n_loaded = 0;
			csc_ready = 1'b0;
		end
		default: begin
			// Unknown opcodes leave the state alone and report ok.
		end
		endcase
		r.count = n_loaded[CNT_OUT_W-1:0];
		return r;
	endfunction

	function automatic logic [VAL_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Hand one command to the driver and keep the load-count guess in step.
	task automatic queue_cmd(input logic [OP_W-1:0] o, input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c, input logic [VAL_W-1:0] v,
			input logic [RIDX_W-1:0] ri);
		command_t cmd;
		cmd = '{o, r, c, v, ri};
		queued_commands.push_back(cmd);
		n_queued++;
		if (o == tcc_pkg::OP_CLEAR)
			est_loaded = 0;
		else if (o == tcc_pkg::OP_APPEND && est_loaded < NUM_SLOTS && c < effective_cols())
			est_loaded++;
	endtask

	// Queue a command of the given opcode with every field random.
	task automatic queue_random(input logic [OP_W-1:0] o);
		queue_cmd(o, ROW_W'($urandom), COL_W'($urandom), rand64(), RIDX_W'($urandom));
	endtask

	// Append with random content; mostly a legal column, now and then any column.
	task automatic queue_append();
		logic [COL_W-1:0] c;
		if (effective_cols() > 0 && $urandom_range(9) != 0)
			c = COL_W'($urandom_range(0, effective_cols() - 1));
		else
			c = COL_W'($urandom);
		queue_cmd(tcc_pkg::OP_APPEND, ROW_W'($urandom), c, rand64(), RIDX_W'($urandom));
	endtask

	// Pointer or entry read aimed around the valid range, with some wild indexes.
	task automatic queue_read();
		logic [OP_W-1:0]   o;
		int unsigned       bound;
		logic [RIDX_W-1:0] ri;
		o = $urandom_range(1) ? tcc_pkg::OP_RD_PTR : tcc_pkg::OP_RD_ENTRY;
		bound = (o == tcc_pkg::OP_RD_PTR) ? effective_cols() : est_loaded;
		if ($urandom_range(99) < 85)
			ri = RIDX_W'($urandom_range(0, bound + 1));
		else
			ri = RIDX_W'($urandom);
		queue_cmd(o, ROW_W'($urandom), COL_W'($urandom), rand64(), ri);
	endtask

	// Write num_cols over its own channel; the converter is idle whenever this runs.
	task automatic write_num_cols(input logic [NCOL_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		cols_setting = v;
		n_cfg++;
	endtask

	// Hold until every queued command went in and every predicted result came out.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (queued_commands.size() != 0 || start || busy || predicted_results.size() != 0);
	endtask

	task automatic report_field(input string name, input logic [VAL_W-1:0] want,
			input logic [VAL_W-1:0] got);
		n_errors++;
		$display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
	endtask

	// Driver: a transaction goes in at an edge where start is high and busy is low.
	// Predict its result right there, then either hold, load the next command or idle.
	always @(posedge clk or negedge arst_n) begin : drive_commands
		command_t nxt;
		if (!arst_n) begin
			start      <= 1'b0;
			op         <= '0;
			row_index  <= '0;
			col_index  <= '0;
			value_word <= '0;
			read_index <= '0;
		end else begin
			if (start && !busy) begin
				predicted_results.push_back(predict_response(
					'{op, row_index, col_index, value_word, read_index}));
				n_accepted++;
			end
			// While busy stalls a pending command, hold it untouched.
			if (!start || !busy) begin
				if (queued_commands.size() != 0 && $urandom_range(99) >= idle_pct) begin
					nxt = queued_commands.pop_front();
					start      <= 1'b1;
					op         <= nxt.op;
					row_index  <= nxt.row;
					col_index  <= nxt.col;
					value_word <= nxt.val;
					read_index <= nxt.ridx;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: done marks a one-cycle result; compare it with the oldest prediction.
	always @(posedge clk) begin : check_results
		response_t want;
		if (arst_n && done) begin
			if (predicted_results.size() == 0) begin
				n_errors++;
				$display("%0t ns: unexpected result, status 0x%0h, count 0x%0h",
					$time, status, entry_count);
			end else begin
				want = predicted_results.pop_front();
				n_checked++;
				if (status !== want.status)
					report_field("status", VAL_W'(want.status), VAL_W'(status));
				if (pointer_out !== want.ptr)
					report_field("pointer_out", VAL_W'(want.ptr), VAL_W'(pointer_out));
				if (row_out !== want.row)
					report_field("row_out", VAL_W'(want.row), VAL_W'(row_out));
				if (value_out !== want.val)
					report_field("value_out", want.val, value_out);
				if (entry_count !== want.count)
					report_field("entry_count", VAL_W'(want.count), VAL_W'(entry_count));
			end
		end
	end

	// Watchdog: far beyond the slowest legal run.
	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still owed",
				n_cycles, predicted_results.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin : stimulus
		logic [NCOL_W-1:0] setting;
		int                phase_end;
		int                n;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, at the reset column count of 256.
		// Reads before any compress report not-compressed.
		queue_cmd(tcc_pkg::OP_RD_PTR, '0, '0, '0, '0);
		queue_cmd(tcc_pkg::OP_RD_ENTRY, '0, '0, '0, '0);
		// Field extremes: first and last column, zero and all-ones content.
		queue_cmd(tcc_pkg::OP_APPEND, '0, '0, '0, '0);
		queue_cmd(tcc_pkg::OP_APPEND, '1, '1, '1, '1);
		queue_cmd(tcc_pkg::OP_APPEND, 16'h1234, '0, 64'hA5A5_5A5A_0F0F_F0F0, '0);
		queue_cmd(tcc_pkg::OP_APPEND, 16'h8001, 8'd7, 64'h8000_0000_0000_0001, '0);
		// Unknown opcodes above clear.
		for (int u = tcc_pkg::OP_CLEAR + 1; u < (1 << OP_W); u++)
			queue_cmd(OP_W'(u), '1, '1, '1, '1);
		queue_cmd(tcc_pkg::OP_COMPRESS, '0, '0, '0, '0);
		// Pointer reads: first, last column, the end pointer, one past, the top index.
		queue_cmd(tcc_pkg::OP_RD_PTR, '0, '0, '0, '0);
		queue_cmd(tcc_pkg::OP_RD_PTR, '0, '0, '0, RIDX_W'(NUM_COLS_MAX - 1));
		queue_cmd(tcc_pkg::OP_RD_PTR, '0, '0, '0, RIDX_W'(NUM_COLS_MAX));
		queue_cmd(tcc_pkg::OP_RD_PTR, '0, '0, '0, RIDX_W'(NUM_COLS_MAX + 1));
		queue_cmd(tcc_pkg::OP_RD_PTR, '0, '0, '0, '1);
		// Entry reads: all four stored positions, column 0 in load order, then the bad positions.
		for (int k = 0; k < 5; k++)
			queue_cmd(tcc_pkg::OP_RD_ENTRY, '0, '0, '0, RIDX_W'(k));
		queue_cmd(tcc_pkg::OP_RD_ENTRY, '0, '0, '0, '1);
		// A good append drops the compressed view; clear empties the store.
		queue_cmd(tcc_pkg::OP_APPEND, 16'h00FF, 8'd3, 64'h1, '0);
		queue_cmd(tcc_pkg::OP_RD_PTR, '0, '0, '0, '0);
		queue_cmd(tcc_pkg::OP_CLEAR, '0, '0, '0, '0);
		queue_cmd(tcc_pkg::OP_RD_ENTRY, '0, '0, '0, '0);
		wait_drained();

		// Random phases, each at its own column count, with one of three idling patterns.
		for (int p = 0; p < 12; p++) begin
			case (p)
			0:       setting = 9'd256;
			1:       setting = 9'd1;
			2:       setting = 9'd0;
			3:       setting = 9'd511;
			4:       setting = 9'd16;
			5:       setting = 9'd3;
			6:       setting = 9'd300;
			7:       setting = 9'd255;
			8:       setting = 9'd257;
			9:       setting = 9'd40;
			10:      setting = 9'd8;
			default: setting = 9'd100;
			endcase
			write_num_cols(setting);
			case (p % 4)
			1:       idle_pct = 71;
			3:       idle_pct = 37;
			default: idle_pct = 0;
			endcase
			// Compress what the last phase left under the new count: a shrink drops
			// the entries that now sit beyond the last column.
			queue_random(tcc_pkg::OP_COMPRESS);
			repeat (4)
				queue_read();
			phase_end = n_queued + PHASE_ITEMS;
			while (n_queued < phase_end) begin
				if ($urandom_range(99) < 75) begin
					// Well-formed: optional clear, a load, compress, then reads.
					if ($urandom_range(1))
						queue_random(tcc_pkg::OP_CLEAR);
					n = $urandom_range(0, 40);
					repeat (n)
						queue_append();
					queue_random(tcc_pkg::OP_COMPRESS);
					repeat ($urandom_range(2, 14))
						queue_read();
				end else begin
					// Noise: any opcode, every field random.
					repeat ($urandom_range(1, 8))
						queue_random(OP_W'($urandom));
				end
			end
			wait_drained();
		end

		// Give a stray late result time to show up, then settle the verdict.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (predicted_results.size() != 0) begin
			n_errors += predicted_results.size();
			$display("%0d predicted results never arrived", predicted_results.size());
		end
		$display("Run covered %0d commands with %0d compressions over %0d column settings,",
			n_accepted, n_compress, n_cfg);
		$display("and %0d results compared field by field, %0d field errors.",
			n_checked, n_errors);
		if (n_errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/tcc_pkg.sv
hw/rtl/tcc_ram.sv
hw/rtl/triplet_to_csc_converter_core.sv
verif/triplet_to_csc_converter_core_tb.sv
